>>> rtl/hsvt_pkg.sv
// ----------------------------------------------------------------------------
// hsvt_pkg: shared constants and the entry compare for the heap sorter
// Widths of the pair store, sort mode codes and the order function.
// ----------------------------------------------------------------------------
package hsvt_pkg;

	localparam int DEPTH    = 64;
	localparam int TAG_BITS = 16;
	localparam int AW       = $clog2(DEPTH);
	localparam int CW       = $clog2(DEPTH + 1);

	localparam logic [1:0] MODE_ASC_VAL  = 2'd0;
	localparam logic [1:0] MODE_DESC_VAL = 2'd1;
	localparam logic [1:0] MODE_ASC_TAG  = 2'd2;
	localparam logic [1:0] MODE_DESC_TAG = 2'd3;

	typedef logic [31:0]       val_t;
	typedef logic [TAG_BITS-1:0] tag_t;
	typedef logic [AW-1:0]     addr_t;
	typedef logic [CW-1:0]     cnt_t;

	function automatic logic f_nan(input val_t x);
		f_nan = (x[30:0] > 31'h7F80_0000);
	endfunction

	function automatic logic f_eq(input val_t a, input val_t b);
		logic z;
		z = ((a[30:0] | b[30:0]) == 31'd0);
		f_eq = !f_nan(a) && !f_nan(b) && (z || (a == b));
	endfunction

	function automatic val_t okey(input val_t x);
		okey = x[31] ? ~x : (x | 32'h8000_0000);
	endfunction

	function automatic logic f_lt(input val_t a, input val_t b);
		f_lt = !f_nan(a) && !f_nan(b) && !f_eq(a, b) && (okey(a) < okey(b));
	endfunction

	// true when entry a should sink below entry b
	function automatic logic sinks(input logic [1:0] mode, input val_t va, input tag_t ta,
			input val_t vb, input tag_t tb);
		case (mode)
			MODE_ASC_VAL:  sinks = f_lt(va, vb) || (f_eq(va, vb) && ta < tb);
			MODE_DESC_VAL: sinks = f_lt(vb, va) || (f_eq(va, vb) && ta > tb);
			MODE_ASC_TAG:  sinks = ta < tb;
			default:       sinks = ta > tb;
		endcase
	endfunction

endpackage

>>> rtl/heap_sort_value_tag_pairs.sv
// ----------------------------------------------------------------------------
// heap_sort_value_tag_pairs: heap sort of float value / tag pairs
// Loads pairs, heap sorts them in the chosen order, streams the sorted run.
// ----------------------------------------------------------------------------
// Words are loaded one per cycle into a 64-entry pair memory; words past the
// 64th are dropped and flag every result of that run. The word marked last
// starts an in-place heap sort run by a sequencer around one registered
// compare unit. The memory has one registered read port and one write port,
// and the sifted pair is held in registers, so one sift level with two
// children takes two child reads, a child compare and a parent compare,
// each with its wait state, and one write; a level with one child skips
// the second read and the child compare. Each build sift adds a parent read
// and a final write, each extraction a root and slot read, a root write to
// the slot and a final write. The sorted run then drains word by word, each
// read only once the output register is free or being taken. Input stall is
// high from the last word until the final word has been moved into the
// output register. sort_mode must only be written between runs.
module heap_sort_value_tag_pairs (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_wdata,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [31:0]    key_value,
	input  logic [15:0]    tag_index,
	input  logic           last_item,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [31:0]    sorted_value,
	output logic [15:0]    sorted_tag,
	output logic           final_result,
	output logic           items_dropped
);
	import hsvt_pkg::*;

	localparam logic [4:0] S_LOAD  = 5'd0;
	localparam logic [4:0] S_BUILD = 5'd1;
	localparam logic [4:0] S_RP    = 5'd2;
	localparam logic [4:0] S_RJ    = 5'd3;
	localparam logic [4:0] S_RJ1   = 5'd4;
	localparam logic [4:0] S_RJ2   = 5'd5;
	localparam logic [4:0] S_CJW   = 5'd6;
	localparam logic [4:0] S_CJ    = 5'd7;
	localparam logic [4:0] S_CKW   = 5'd8;
	localparam logic [4:0] S_CK    = 5'd9;
	localparam logic [4:0] S_SW    = 5'd10;
	localparam logic [4:0] S_FIN   = 5'd11;
	localparam logic [4:0] S_EXR   = 5'd12;
	localparam logic [4:0] S_EXR1  = 5'd13;
	localparam logic [4:0] S_EXW   = 5'd14;
	localparam logic [4:0] S_DRAIN = 5'd15;
	localparam logic [4:0] S_DWAIT = 5'd16;

	// pair memory
	val_t vmem [DEPTH];
	tag_t tmem [DEPTH];
	logic  we;
	addr_t wa, ra;
	val_t  wv, rv_q;
	tag_t  wt, rt_q;

	logic [4:0] st_q;
	logic [1:0] mode_q;
	cnt_t       cnt_q;
	logic       ovf_q;
	logic       build_q;
	cnt_t       i_q;       // build index / extraction slot / drain index
	cnt_t       k_q, j_q;  // sift parent and child (j can reach 2*last+1)
	cnt_t       sl_q;      // last index of the current sift
	val_t       vk_q, vc_q, va_q, vb_q;
	tag_t       tk_q, tc_q, ta_q, tb_q;
	logic       cmp_q;
	logic       have_q;    // output register full
	val_t       ov_q;
	tag_t       ot_q;
	logic       of_q;
	logic       od_q;
	cnt_t       cnt_inc, i_inc, i_dec, j_inc;
	logic       room;
	logic       in_acc;
	logic       out_take;

	always_ff @(posedge clk) begin
		if (we) begin
			vmem[wa] <= wv;
			tmem[wa] <= wt;
		end
		rv_q <= vmem[ra];
		rt_q <= tmem[ra];
	end

	hsvt_cmp u_cmp (
		.clk(clk), .mode(mode_q), .va(va_q), .ta(ta_q), .vb(vb_q), .tb(tb_q), .res_q(cmp_q)
	);

	assign in_stall      = (st_q != S_LOAD);
	assign out_valid     = have_q;
	assign sorted_value  = ov_q;
	assign sorted_tag    = 16'(ot_q);
	assign final_result  = of_q;
	assign items_dropped = od_q;

	assign in_acc   = in_valid && !in_stall;
	assign out_take = have_q && !out_stall;
	assign room     = (cnt_q < cnt_t'(DEPTH));
	assign cnt_inc  = cnt_q + cnt_t'(1);
	assign i_inc    = i_q + cnt_t'(1);
	assign i_dec    = i_q - cnt_t'(1);
	assign j_inc    = j_q + cnt_t'(1);

	// memory port steering
	always_comb begin
		we = 1'b0;
		wa = addr_t'(cnt_q);
		wv = key_value;
		wt = tag_t'(tag_index);
		ra = addr_t'(j_q);
		case (st_q)
			S_LOAD:  we = in_acc && room;
			S_BUILD: ra = addr_t'(i_dec);
			S_RJ1:   ra = addr_t'(j_inc);
			S_SW: begin
				we = 1'b1;
				wa = addr_t'(k_q); wv = vc_q; wt = tc_q;
			end
			S_FIN: begin
				we = 1'b1;
				wa = addr_t'(k_q); wv = vk_q; wt = tk_q;
			end
			S_EXR:   ra = addr_t'(0);
			S_EXR1:  ra = addr_t'(i_q);
			S_EXW: begin
				we = 1'b1;
				wa = addr_t'(i_q); wv = vc_q; wt = tc_q;
			end
			S_DRAIN: ra = addr_t'(i_q);
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_LOAD;
			mode_q  <= MODE_ASC_VAL;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			build_q <= 1'b0;
			i_q     <= '0;
			k_q     <= '0;
			j_q     <= '0;
			sl_q    <= '0;
			vk_q    <= '0;
			tk_q    <= '0;
			vc_q    <= '0;
			tc_q    <= '0;
			va_q    <= '0;
			ta_q    <= '0;
			vb_q    <= '0;
			tb_q    <= '0;
			have_q  <= 1'b0;
			ov_q    <= '0;
			ot_q    <= '0;
			of_q    <= 1'b0;
			od_q    <= 1'b0;
		end else begin
			if (cfg_we) mode_q <= cfg_wdata;
			// output register
			if (st_q == S_DWAIT) begin
				have_q <= 1'b1;
				ov_q   <= rv_q;
				ot_q   <= rt_q;
				of_q   <= (i_inc == cnt_q);
				od_q   <= ovf_q;
			end else if (out_take) begin
				have_q <= 1'b0;
			end
			case (st_q)
				S_LOAD: if (in_acc) begin
					if (room) cnt_q <= cnt_inc;
					else ovf_q <= 1'b1;
					if (last_item) begin
						// last index and build start for the closed set
						sl_q    <= room ? cnt_q : cnt_t'(DEPTH - 1);
						i_q     <= room ? (cnt_inc >> 1) : cnt_t'(DEPTH / 2);
						build_q <= 1'b1;
						st_q    <= S_BUILD;
					end
				end
				S_BUILD: begin
					if (i_q == '0) begin
						build_q <= 1'b0;
						if (sl_q == '0) begin
							st_q <= S_DRAIN;
						end else begin
							i_q  <= sl_q;
							st_q <= S_EXR;
						end
					end else begin
						k_q  <= i_dec;
						j_q  <= {i_dec[CW-2:0], 1'b1};
						i_q  <= i_dec;
						st_q <= S_RP;
					end
				end
				S_RP: begin
					vk_q <= rv_q; tk_q <= rt_q;
					st_q <= S_RJ;
				end
				S_RJ: st_q <= (j_q > sl_q) ? S_FIN : S_RJ1;
				S_RJ1: begin
					vc_q <= rv_q; tc_q <= rt_q;
					if (j_q < sl_q) begin
						va_q <= rv_q; ta_q <= rt_q;
						st_q <= S_RJ2;
					end else begin
						// single child: compare parent against it
						va_q <= vk_q; ta_q <= tk_q;
						vb_q <= rv_q; tb_q <= rt_q;
						st_q <= S_CKW;
					end
				end
				S_RJ2: begin
					vb_q <= rv_q; tb_q <= rt_q;
					st_q <= S_CJW;
				end
				S_CJW: st_q <= S_CJ;
				S_CJ: begin
					// pick the child, then compare the parent against it
					if (cmp_q) begin
						j_q  <= j_inc;
						vc_q <= vb_q; tc_q <= tb_q;
					end else begin
						vb_q <= va_q; tb_q <= ta_q;
					end
					va_q <= vk_q; ta_q <= tk_q;
					st_q <= S_CKW;
				end
				S_CKW: st_q <= S_CK;
				S_CK: st_q <= cmp_q ? S_SW : S_FIN;
				S_SW: begin
					k_q  <= j_q;
					j_q  <= {j_q[CW-2:0], 1'b1};
					st_q <= S_RJ;
				end
				S_FIN: begin
					if (build_q) begin
						st_q <= S_BUILD;
					end else if (i_q == cnt_t'(1)) begin
						i_q  <= '0;
						st_q <= S_DRAIN;
					end else begin
						i_q  <= i_dec;
						st_q <= S_EXR;
					end
				end
				S_EXR: st_q <= S_EXR1;
				S_EXR1: begin
					vc_q <= rv_q; tc_q <= rt_q;  // root
					st_q <= S_EXW;
				end
				S_EXW: begin
					// root goes to the slot, old slot pair sifts from the top
					vk_q <= rv_q; tk_q <= rt_q;
					k_q  <= '0;
					j_q  <= cnt_t'(1);
					sl_q <= i_dec;
					st_q <= S_RJ;
				end
				S_DRAIN: if (!have_q || out_take) st_q <= S_DWAIT;
				S_DWAIT: begin
					if (i_inc == cnt_q) begin
						st_q  <= S_LOAD;
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end else begin
						i_q  <= i_inc;
						st_q <= S_DRAIN;
					end
				end
				default: st_q <= S_LOAD;
			endcase
		end
	end
endmodule

>>> rtl/hsvt_cmp.sv
// ----------------------------------------------------------------------------
// hsvt_cmp: shared compare unit
// One ordered compare of two pairs, registered.
// ----------------------------------------------------------------------------
module hsvt_cmp (
	input  logic           clk,
	input  logic [1:0]     mode,
	input  hsvt_pkg::val_t va,
	input  hsvt_pkg::tag_t ta,
	input  hsvt_pkg::val_t vb,
	input  hsvt_pkg::tag_t tb,
	output logic           res_q
);
	import hsvt_pkg::*;

	// registered compare result
	always_ff @(posedge clk) begin
		res_q <= sinks(mode, va, ta, vb, tb);
	end
endmodule

>>> rtl/hsvt_check.sv
// ----------------------------------------------------------------------------
// hsvt_check: port-level checks for the heap sorter
// Handshake and run-framing properties seen at the top level ports.
// ----------------------------------------------------------------------------
module hsvt_check (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic last_item,
	input logic out_valid,
	input logic out_stall,
	input logic final_result
);
	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its final mark
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(final_result))
		else $error("final mark changed while stalled");

	// the closing word blocks further input
	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_item |=> in_stall)
		else $error("input open after last word");

	// no results while loading
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && !out_valid |=> !out_valid || in_stall || $past(in_stall))
		else $error("result while loading");
endmodule

bind heap_sort_value_tag_pairs hsvt_check u_hsvt_check (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.last_item(last_item), .out_valid(out_valid), .out_stall(out_stall),
	.final_result(final_result)
);
